@@ rtl/crp_pkg.sv @@
// shared types and constants of the crp table sampler
`default_nettype none

package crp_pkg;

  localparam int ATOM_SLOTS  = 64;
  localparam int COUNT_BITS  = 16;
  localparam int SLOT_BITS   = $clog2(ATOM_SLOTS);

  localparam int ID_BITS     = 6;
  localparam int U_BITS      = 16;
  localparam int ALPHA_BITS  = 24;
  localparam int TOTAL_BITS  = 24;
  localparam int OUT_CNT_BITS = 16;
  localparam int ALPHA_FRAC  = 8;
  localparam int U_FRAC      = 16;
  localparam int ACC_SHIFT   = ALPHA_FRAC + U_FRAC;
  localparam int W_BITS      = TOTAL_BITS + ALPHA_FRAC + 1;
  localparam int LHS_BITS    = U_BITS + W_BITS;
  localparam int ID_EXT_BITS = ((SLOT_BITS > ID_BITS) ? SLOT_BITS : ID_BITS) + 1;

  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(256);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX   = '1;
  localparam logic [SLOT_BITS-1:0]  LAST_SLOT   = SLOT_BITS'(ATOM_SLOTS - 1);

  typedef enum logic [1:0] {
    OP_SAMPLE      = 2'd0,
    OP_INCORPORATE = 2'd1,
    OP_REMOVE      = 2'd2,
    OP_QUERY       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ABSENT   = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_RMW,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [ID_BITS-1:0]      chosen;
    status_t                 status;
    logic [OUT_CNT_BITS-1:0] count;
    logic [TOTAL_BITS-1:0]   total;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/crp_count_ram.sv @@
// generic single write, single read synchronous ram
`default_nettype none

module crp_count_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/crp_ctrl.sv @@
// sequencer: slot walk for sample, else read-modify-write (query only reads)
`default_nettype none

module crp_ctrl import crp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_operation,
  input  wire logic [ID_BITS-1:0]    in_atom_id,
  input  wire logic [U_BITS-1:0]     in_uniform,
  input  wire logic [ALPHA_BITS-1:0] alpha,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output res_t                       res
);

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [ID_BITS-1:0]      id_r, id_nxt;
  logic [U_BITS-1:0]       u_r, u_nxt;
  logic [W_BITS-1:0]       weight_r, weight_nxt;
  logic [LHS_BITS-1:0]     lhs_r, lhs_nxt;
  logic [TOTAL_BITS-1:0]   acc_r, acc_nxt;
  logic [SLOT_BITS-1:0]    walk_r, walk_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [SLOT_BITS-1:0]    free_slot_r, free_slot_nxt;
  logic [TOTAL_BITS-1:0]   total_r, total_nxt;
  res_t                    res_r, res_nxt;
  logic [ATOM_SLOTS-1:0]   written_r;
  logic [SLOT_BITS-1:0]    rd_addr_r;

  logic [SLOT_BITS-1:0]    rd_addr;
  logic [COUNT_BITS-1:0]   rd_data;
  logic                    wr_en;
  logic [SLOT_BITS-1:0]    wr_addr;
  logic [COUNT_BITS-1:0]   wr_data;

  logic [COUNT_BITS-1:0]   count_cur;
  logic [ID_EXT_BITS-1:0]  id_ext;
  logic                    id_inside;
  logic [SLOT_BITS-1:0]    id_slot;
  logic [TOTAL_BITS-1:0]   acc_sum;
  logic                    hit;

  crp_count_ram #(
    .DEPTH (ATOM_SLOTS),
    .WIDTH (COUNT_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // never-written entries read as zero, which stands in for clearing the table
  assign count_cur = written_r[rd_addr_r] ? rd_data : '0;

  assign id_ext    = ID_EXT_BITS'(id_r);
  assign id_inside = id_ext < ID_EXT_BITS'(ATOM_SLOTS);
  assign id_slot   = SLOT_BITS'(id_ext);

  assign acc_sum = acc_r + TOTAL_BITS'(count_cur);
  assign hit     = (count_cur != '0) &&
                   (lhs_r <= LHS_BITS'({acc_sum, {ACC_SHIFT{1'b0}}}));

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      written_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    u_r          <= u_nxt;
    weight_r     <= weight_nxt;
    lhs_r        <= lhs_nxt;
    acc_r        <= acc_nxt;
    walk_r       <= walk_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    res_r        <= res_nxt;
    rd_addr_r    <= rd_addr;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    u_nxt          = u_r;
    weight_nxt     = weight_r;
    lhs_nxt        = lhs_r;
    acc_nxt        = acc_r;
    walk_nxt       = walk_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    total_nxt      = total_r;
    res_nxt        = res_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = id_slot;
    wr_data        = count_cur;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = SLOT_BITS'(ID_EXT_BITS'(in_atom_id));
        if (in_valid) begin
          op_nxt     = op_t'(in_operation);
          id_nxt     = in_atom_id;
          u_nxt      = in_uniform;
          weight_nxt = W_BITS'(alpha) + (W_BITS'(total_r) << ALPHA_FRAC);
          state_nxt  = (op_t'(in_operation) == OP_SAMPLE) ? S_LOAD : S_RMW;
        end
      end

      S_LOAD: begin
        lhs_nxt        = LHS_BITS'(u_r) * LHS_BITS'(weight_r);
        acc_nxt        = '0;
        walk_nxt       = '0;
        free_found_nxt = 1'b0;
        rd_addr        = '0;
        state_nxt      = S_WALK;
      end

      S_WALK: begin
        rd_addr = walk_r + 1'b1;
        if (count_cur != '0) begin
          acc_nxt = acc_sum;
        end else if (!free_found_r) begin
          free_found_nxt = 1'b1;
          free_slot_nxt  = walk_r;
        end
        res_nxt.total = total_r;
        if (hit) begin
          res_nxt.chosen = ID_BITS'(walk_r);
          res_nxt.status = STATUS_OK;
          res_nxt.count  = OUT_CNT_BITS'(count_cur);
          state_nxt      = S_FIN;
        end else if (walk_r == LAST_SLOT) begin
          res_nxt.count = '0;
          if (free_found_r) begin
            res_nxt.chosen = ID_BITS'(free_slot_r);
            res_nxt.status = STATUS_OK;
          end else if (count_cur == '0) begin
            res_nxt.chosen = ID_BITS'(walk_r);
            res_nxt.status = STATUS_OK;
          end else begin
            res_nxt.chosen = '0;
            res_nxt.status = STATUS_FULL;
          end
          state_nxt = S_FIN;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end

      S_RMW: begin
        res_nxt.chosen = id_r;
        res_nxt.status = STATUS_OK;
        res_nxt.count  = '0;
        res_nxt.total  = total_r;
        case (op_r)
          OP_INCORPORATE: begin
            if (!id_inside) begin
              res_nxt.status = STATUS_FULL;
            end else if (count_cur == COUNT_MAX || total_r == TOTAL_MAX) begin
              res_nxt.status = STATUS_OVERFLOW;
              res_nxt.count  = OUT_CNT_BITS'(count_cur);
            end else begin
              wr_en          = 1'b1;
              wr_data        = count_cur + 1'b1;
              total_nxt      = total_r + 1'b1;
              res_nxt.count  = OUT_CNT_BITS'(wr_data);
              res_nxt.total  = total_nxt;
            end
          end
          OP_REMOVE: begin
            if (!id_inside || count_cur == '0) begin
              res_nxt.status = STATUS_ABSENT;
            end else begin
              wr_en   = 1'b1;
              wr_data = count_cur - 1'b1;
              if (total_r != '0) begin
                total_nxt = total_r - 1'b1;
              end
              res_nxt.count = OUT_CNT_BITS'(wr_data);
              res_nxt.total = total_nxt;
            end
          end
          default: begin
            if (id_inside) begin
              res_nxt.count = OUT_CNT_BITS'(count_cur);
            end
          end
        endcase
        state_nxt = S_FIN;
      end

      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/crp_table_sampler.sv @@
// top level of the crp table sampler: config register, sequencer and result register
`default_nettype none

// Table sampler for a Chinese restaurant process. One count per atom slot is
// held in a single-port-read, single-port-write ram, plus a running client
// total. Operations: sample (walk the slots in ascending order and pick the
// first occupied slot whose running count sum reaches uniform * (alpha +
// clients), else the lowest free slot, else report table full), incorporate,
// remove and query. One item is in work at a time. A sample runs a setup
// step for the weight product, then walks one slot per cycle through the ram
// read port, stopping early when a slot hits, then hands off to the output
// register; incorporate, remove and query run a ram read, a write back
// (none for query) and the hand-off. A new input transfer is taken as soon
// as the result sits in the output register, even while that result still
// waits to be taken. After reset the table reads as cleared at once: a
// per-slot written flag masks stale ram contents, so there is no clearing
// pass. The alpha register (8 fraction bits) resets to 1.0; the user must
// write it only while the block is idle, which the block does not enforce.

module crp_table_sampler import crp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  // configuration write channel
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [ALPHA_BITS-1:0]   cfg_alpha_weight,

  // input channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_operation,
  input  wire logic [ID_BITS-1:0]      in_atom_id,
  input  wire logic [U_BITS-1:0]       in_uniform,

  // result channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [ID_BITS-1:0]           out_chosen_atom,
  output logic [1:0]                   out_status,
  output logic [OUT_CNT_BITS-1:0]      out_atom_count,
  output logic [TOTAL_BITS-1:0]        out_client_total
);

  logic [ALPHA_BITS-1:0] alpha_r;
  logic                  out_valid_r;
  res_t                  out_res_r;

  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;

  // config is always accepted; the user must only send it while no item is in flight
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_valid) begin
      alpha_r <= cfg_alpha_weight;
    end
  end

  crp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_atom_id   (in_atom_id),
    .in_uniform   (in_uniform),
    .alpha        (alpha_r),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register: takes a result when empty or when its current one leaves
  assign res_ready = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_atom  = out_res_r.chosen;
  assign out_status       = out_res_r.status;
  assign out_atom_count   = out_res_r.count;
  assign out_client_total = out_res_r.total;

endmodule

`default_nettype wire

@@ sim/crp_table_sampler_tb.sv @@
// testbench of the crp table sampler: directed table, random traffic, table predictor
`default_nettype none

module crp_table_sampler_tb import crp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // receiver hold-off used once to back the block up into its input
  localparam int HOLD_OFF_CYCLES = 400;
  // atom that takes a back-to-back incorporate burst
  localparam logic [ID_BITS-1:0] BURST_ATOM = ID_BITS'(37);
  localparam int BURST_LEN = 32;

  // one row of the directed table; want is only used when has_want is set
  typedef struct {
    op_t                op;
    logic [ID_BITS-1:0] id;
    logic [U_BITS-1:0]  u;
    bit                 has_want;
    res_t               want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [ALPHA_BITS-1:0]   cfg_alpha_weight = '0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_operation = '0;
  logic [ID_BITS-1:0]      in_atom_id = '0;
  logic [U_BITS-1:0]       in_uniform = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ID_BITS-1:0]      out_chosen_atom;
  logic [1:0]              out_status;
  logic [OUT_CNT_BITS-1:0] out_atom_count;
  logic [TOTAL_BITS-1:0]   out_client_total;

  // predictor state: our own copy of the table, the seated total and alpha
  logic [COUNT_BITS-1:0]   table_counts [ATOM_SLOTS];
  logic [TOTAL_BITS-1:0]   seated_total;
  logic [ALPHA_BITS-1:0]   alpha_model;

  res_t      awaited_results [$];
  stim_row_t directed_rows [$];
  int        mismatch_count = 0;

  // shared between the sender and the receiver processes
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;

  always #5 clk = ~clk;

  crp_table_sampler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_alpha_weight (cfg_alpha_weight),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_atom_id       (in_atom_id),
    .in_uniform       (in_uniform),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chosen_atom  (out_chosen_atom),
    .out_status       (out_status),
    .out_atom_count   (out_atom_count),
    .out_client_total (out_client_total)
  );

  // idle length for either side: mostly none or short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic res_t make_want(int chosen, status_t st, int cnt, int tot);
    res_t r;
    r.chosen = ID_BITS'(chosen);
    r.status = st;
    r.count  = OUT_CNT_BITS'(cnt);
    r.total  = TOTAL_BITS'(tot);
    return r;
  endfunction

  function automatic stim_row_t make_row(op_t op, int id, int u, bit has_want, res_t want);
    stim_row_t s;
    s.op       = op;
    s.id       = ID_BITS'(id);
    s.u        = U_BITS'(u);
    s.has_want = has_want;
    s.want     = want;
    return s;
  endfunction

  // appends one row to the directed table
  function automatic void add_row(stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // works out the result of one table operation and applies it to the copy of the state
  function automatic res_t predict_table_op(op_t op, logic [ID_BITS-1:0] id,
                                            logic [U_BITS-1:0] u);
    res_t       r;
    logic [63:0] weight;
    logic [63:0] lhs;
    logic [63:0] acc;
    bit          found;
    int          i;
    r.chosen = id;
    r.status = STATUS_OK;
    r.count  = '0;
    case (op)
      OP_SAMPLE: begin
        // exact compare: u * (alpha + clients * 2^8) against running sum * 2^24
        weight = 64'(alpha_model) + (64'(seated_total) << ALPHA_FRAC);
        lhs    = 64'(u) * weight;
        acc    = '0;
        found  = 1'b0;
        for (i = 0; i < ATOM_SLOTS && !found; i++) begin
          if (table_counts[i] != '0) begin
            acc = acc + 64'(table_counts[i]);
            if (lhs <= (acc << ACC_SHIFT)) begin
              found    = 1'b1;
              r.chosen = ID_BITS'(i);
              r.count  = OUT_CNT_BITS'(table_counts[i]);
            end
          end
        end
        // nothing qualified: open a new table at the lowest free slot
        for (i = 0; i < ATOM_SLOTS && !found; i++) begin
          if (table_counts[i] == '0) begin
            found    = 1'b1;
            r.chosen = ID_BITS'(i);
          end
        end
        if (!found) begin
          r.chosen = '0;
          r.status = STATUS_FULL;
        end
      end
      OP_INCORPORATE: begin
        if (table_counts[id] == COUNT_MAX || seated_total == TOTAL_MAX) begin
          r.status = STATUS_OVERFLOW;
          r.count  = OUT_CNT_BITS'(table_counts[id]);
        end else begin
          table_counts[id] = table_counts[id] + 1'b1;
          seated_total     = seated_total + 1'b1;
          r.count          = OUT_CNT_BITS'(table_counts[id]);
        end
      end
      OP_REMOVE: begin
        if (table_counts[id] == '0) begin
          r.status = STATUS_ABSENT;
        end else begin
          table_counts[id] = table_counts[id] - 1'b1;
          if (seated_total != '0) seated_total = seated_total - 1'b1;
          r.count = OUT_CNT_BITS'(table_counts[id]);
        end
      end
      default: begin
        r.count = OUT_CNT_BITS'(table_counts[id]);
      end
    endcase
    r.total = seated_total;
    return r;
  endfunction

  // offer one item, called at a rising edge; valid is only lowered when a gap is wanted
  task automatic offer(input op_t op, input logic [ID_BITS-1:0] id,
                       input logic [U_BITS-1:0] u, input bit has_want, input res_t want);
    int   gap;
    res_t pred;
    gap = no_idle ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_atom_id   <= id;
    in_uniform   <= u;
    do @(posedge clk); while (!(in_valid && in_ready));
    // the predictor always runs so that its state follows the block
    pred = predict_table_op(op, id, u);
    awaited_results.insert(awaited_results.size(), has_want ? want : pred);
  endtask

  // stop offering and wait until every awaited result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // alpha is only written while the block is idle
  task automatic write_alpha(input logic [ALPHA_BITS-1:0] value);
    drain();
    cfg_valid        <= 1'b1;
    cfg_alpha_weight <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    alpha_model = value;
    cfg_valid  <= 1'b0;
  endtask

  // random traffic: ids biased towards a small pool so counts build up and removes hit
  task automatic run_random(input int n, input int sample_pct);
    op_t                op;
    logic [ID_BITS-1:0] id;
    logic [U_BITS-1:0]  u;
    int                 r;
    int                 k;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < sample_pct) begin
        op = OP_SAMPLE;
      end else begin
        r = $urandom_range(0, 9);
        op = (r < 5) ? OP_INCORPORATE : (r < 8) ? OP_REMOVE : OP_QUERY;
      end
      r = $urandom_range(0, 7);
      if ($urandom_range(0, 99) < 60) id = ID_BITS'((r < 4) ? r : 56 + r);
      else id = ID_BITS'($urandom_range(0, ATOM_SLOTS - 1));
      r = $urandom_range(0, 99);
      if (r < 10) u = '0;
      else if (r < 20) u = '1;
      else if (r < 50) u = U_BITS'($urandom_range(0, 16'h0fff));
      else u = U_BITS'($urandom());
      offer(op, id, u, 1'b0, res_t'(0));
    end
  endtask

  // result side: checks each transfer, then decides ready for the next cycle
  initial begin : result_side
    int   stall_left;
    res_t want;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transfer, chosen %0d status %0d count %0d total %0d",
                   $realtime, out_chosen_atom, out_status, out_atom_count, out_client_total);
        end else begin
          want = awaited_results.pop_front();
          if (out_chosen_atom !== want.chosen) begin
            mismatch_count++;
            $display("%0t: chosen_atom expected %0d, got %0d",
                     $realtime, want.chosen, out_chosen_atom);
          end
          if (out_status !== want.status) begin
            mismatch_count++;
            $display("%0t: status expected %0d, got %0d", $realtime, want.status, out_status);
          end
          if (out_atom_count !== want.count) begin
            mismatch_count++;
            $display("%0t: atom_count expected %0d, got %0d",
                     $realtime, want.count, out_atom_count);
          end
          if (out_client_total !== want.total) begin
            mismatch_count++;
            $display("%0t: client_total expected %0d, got %0d",
                     $realtime, want.total, out_client_total);
          end
        end
      end
      // one assignment to out_ready per edge
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_off_req) begin
        // long hold-off: the block fills up and must stall its input
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES - 1;
        out_ready   <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 15) begin
        stall_left = idle_length();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog, well beyond the slowest correct run
  initial begin : watchdog
    #40_000_000;
    $display("crp_table_sampler_tb failed");
    $finish;
  end

  initial begin : stimulus
    int k;
    for (k = 0; k < ATOM_SLOTS; k++) table_counts[k] = '0;
    seated_total = '0;
    alpha_model  = ALPHA_RESET;

    // directed table; expectations typed in where they follow from the cleared table
    add_row(make_row(OP_QUERY, 0, 0, 1'b1,
                     make_want(0, STATUS_OK, 0, 0)));
    // empty table: no occupied slot, so slot 0 opens
    add_row(make_row(OP_SAMPLE, 0, 0, 1'b1,
                     make_want(0, STATUS_OK, 0, 0)));
    add_row(make_row(OP_REMOVE, 5, 0, 1'b1,
                     make_want(5, STATUS_ABSENT, 0, 0)));
    add_row(make_row(OP_INCORPORATE, 63, 16'hffff, 1'b1,
                     make_want(63, STATUS_OK, 1, 1)));
    // zero draw lands on the first occupied slot
    add_row(make_row(OP_SAMPLE, 0, 0, 1'b1,
                     make_want(63, STATUS_OK, 1, 1)));
    // top draw exceeds the single count, new table at slot 0
    add_row(make_row(OP_SAMPLE, 63, 16'hffff, 1'b1,
                     make_want(0, STATUS_OK, 0, 1)));
    add_row(make_row(OP_INCORPORATE, 42, 0, 1'b1,
                     make_want(42, STATUS_OK, 1, 2)));
    add_row(make_row(OP_INCORPORATE, 21, 0, 1'b1,
                     make_want(21, STATUS_OK, 1, 3)));
    add_row(make_row(OP_INCORPORATE, 21, 0, 1'b1,
                     make_want(21, STATUS_OK, 2, 4)));
    add_row(make_row(OP_QUERY, 21, 0, 1'b1,
                     make_want(21, STATUS_OK, 2, 4)));
    add_row(make_row(OP_SAMPLE, 0, 16'h8000, 1'b0, res_t'(0)));
    add_row(make_row(OP_SAMPLE, 0, 16'h5555, 1'b0, res_t'(0)));
    add_row(make_row(OP_SAMPLE, 63, 16'haaaa, 1'b0, res_t'(0)));
    add_row(make_row(OP_REMOVE, 42, 0, 1'b1,
                     make_want(42, STATUS_OK, 0, 3)));
    // second remove finds the atom gone
    add_row(make_row(OP_REMOVE, 42, 0, 1'b1,
                     make_want(42, STATUS_ABSENT, 0, 3)));
    add_row(make_row(OP_QUERY, 42, 0, 1'b1,
                     make_want(42, STATUS_OK, 0, 3)));
    add_row(make_row(OP_REMOVE, 63, 0, 1'b1,
                     make_want(63, STATUS_OK, 0, 2)));
    add_row(make_row(OP_REMOVE, 21, 0, 1'b1,
                     make_want(21, STATUS_OK, 1, 1)));
    add_row(make_row(OP_REMOVE, 21, 0, 1'b1,
                     make_want(21, STATUS_OK, 0, 0)));
    add_row(make_row(OP_SAMPLE, 0, 16'h1234, 1'b1,
                     make_want(0, STATUS_OK, 0, 0)));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset alpha of 1.0
    foreach (directed_rows[k]) begin
      offer(directed_rows[k].op, directed_rows[k].id, directed_rows[k].u,
            directed_rows[k].has_want, directed_rows[k].want);
    end

    // smallest nonzero alpha, with the long receiver hold-off early in the phase
    write_alpha(ALPHA_BITS'(1));
    hold_off_req = 1'b1;
    run_random(200, 35);

    // alpha zero is taken as written
    write_alpha('0);
    run_random(150, 35);

    // largest alpha; fill every slot so high draws report a full table
    write_alpha('1);
    for (k = 0; k < ATOM_SLOTS; k++) begin
      if (table_counts[k] == '0) begin
        offer(OP_INCORPORATE, ID_BITS'(k), U_BITS'($urandom()), 1'b0, res_t'(0));
      end
    end
    run_random(200, 60);

    // burst with no idling on either side, all on one atom
    no_idle = 1'b1;
    repeat (BURST_LEN) begin
      offer(OP_INCORPORATE, BURST_ATOM, U_BITS'($urandom()), 1'b0, res_t'(0));
    end
    no_idle = 1'b0;
    // one more, a read back, a top draw, then down and up again on the same atom
    offer(OP_INCORPORATE, BURST_ATOM, '0, 1'b0, res_t'(0));
    offer(OP_QUERY, BURST_ATOM, '0, 1'b0, res_t'(0));
    offer(OP_SAMPLE, '0, '1, 1'b0, res_t'(0));
    offer(OP_REMOVE, BURST_ATOM, '0, 1'b0, res_t'(0));
    offer(OP_INCORPORATE, BURST_ATOM, '0, 1'b0, res_t'(0));
    offer(OP_INCORPORATE, BURST_ATOM, '0, 1'b0, res_t'(0));

    // a random alpha over the heavy table
    write_alpha(ALPHA_BITS'($urandom()));
    run_random(250, 35);

    // back to the reset value
    write_alpha(ALPHA_RESET);
    run_random(250, 35);

    // small random alpha to finish
    write_alpha(ALPHA_BITS'($urandom_range(1, 4096)));
    run_random(100, 35);

    drain();
    // allow for any stray result beyond the longest sample walk
    repeat (ATOM_SLOTS + 16) @(posedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("crp_table_sampler_tb passed");
    end else begin
      $display("crp_table_sampler_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ crp_table_sampler.f @@
rtl/crp_pkg.sv
rtl/crp_count_ram.sv
rtl/crp_ctrl.sv
rtl/crp_table_sampler.sv
sim/crp_table_sampler_tb.sv
